@@ hdl/client_peer_table_defines.svh @@
// Assertion helpers; the using module supplies aclk and aresetn.
`ifndef CLIENT_PEER_TABLE_DEFINES_SVH
`define CLIENT_PEER_TABLE_DEFINES_SVH

// Condition that holds at every edge out of reset.
`define CPT_ASSERT_ALWAYS(lbl, expr, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (expr)) else $error(msg);

// Condition that holds in the cycle after a trigger.
`define CPT_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hdl/cpt_pkg.sv @@
package cpt_pkg;

    localparam int OP_W        = 3;
    localparam int ID_W        = 64;
    localparam int CNT_OUT_W   = 5;
    localparam int MAX_RESULTS = 16;
    localparam int IN_DATA_W   = 200;   // 193 bits of fields, padded to bytes
    localparam int OUT_DATA_W  = 136;   // 134 bits of fields, padded to bytes

    localparam logic [OP_W-1:0] OP_ADD       = 3'd0;
    localparam logic [OP_W-1:0] OP_CHECK     = 3'd1;
    localparam logic [OP_W-1:0] OP_DROP_NODE = 3'd2;
    localparam logic [OP_W-1:0] OP_DROP_CONN = 3'd3;
    localparam logic [OP_W-1:0] OP_LIST      = 3'd4;
    localparam logic [OP_W-1:0] OP_CONTAINS  = 3'd5;

    typedef enum logic [2:0] {
        K_ADD, K_CHECK, K_DROP_NODE, K_DROP_CONN, K_LIST, K_CONTAINS, K_BAD
    } kind_t;

    typedef struct packed {
        kind_t             kind;
        logic [ID_W-1:0]   node_id;
        logic [ID_W-1:0]   conn_id;
        logic              bucket_unset;
        logic              dist_ok;     // id checks and XOR distance test passed
    } cmd_t;

endpackage

@@ hdl/cpt_ram.sv @@
module cpt_ram #(
    parameter int WIDTH = 128,
    parameter int DEPTH = 16
) (
    input  logic                                    aclk,
    input  logic                                    we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                        wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                        rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

@@ hdl/cpt_front.sv @@
module cpt_front (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic [cpt_pkg::ID_W-1:0]     own_id,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [cpt_pkg::OP_W-1:0]     in_op,
    input  logic [cpt_pkg::ID_W-1:0]     in_node_id,
    input  logic [cpt_pkg::ID_W-1:0]     in_conn_id,
    input  logic                         in_bucket_unset,
    input  logic [cpt_pkg::ID_W-1:0]     in_far_id,
    output logic                         q_valid,
    input  logic                         q_ready,
    output cpt_pkg::cmd_t                q_cmd
);
    import cpt_pkg::*;

    // two-entry command queue
    cmd_t        slot_reg [2];
    logic        wptr_reg, rptr_reg;
    logic [1:0]  count_reg;
    cmd_t        dec;
    logic        push, pop;

    always_comb begin
        unique case (in_op)
            OP_ADD:       dec.kind = K_ADD;
            OP_CHECK:     dec.kind = K_CHECK;
            OP_DROP_NODE: dec.kind = K_DROP_NODE;
            OP_DROP_CONN: dec.kind = K_DROP_CONN;
            OP_LIST:      dec.kind = K_LIST;
            OP_CONTAINS:  dec.kind = K_CONTAINS;
            default:      dec.kind = K_BAD;
        endcase
        dec.node_id       = in_node_id;
        dec.conn_id       = in_conn_id;
        dec.bucket_unset  = in_bucket_unset;
        dec.dist_ok       = (in_node_id != own_id) && (in_far_id != in_node_id) &&
                            ((in_far_id ^ own_id) > (in_node_id ^ own_id));
    end

    assign in_ready = (count_reg != 2'd2);
    assign q_valid  = (count_reg != 2'd0);
    assign q_cmd    = slot_reg[rptr_reg];
    assign push     = in_valid && in_ready;
    assign pop      = q_valid && q_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wptr_reg  <= 1'b0;
            rptr_reg  <= 1'b0;
            count_reg <= 2'd0;
        end else begin
            if (push) begin
                slot_reg[wptr_reg] <= dec;
                wptr_reg           <= ~wptr_reg;
            end
            if (pop) begin
                rptr_reg <= ~rptr_reg;
            end
            count_reg <= count_reg + {1'b0, push} - {1'b0, pop};
        end
    end
endmodule

@@ hdl/cpt_engine.sv @@
`include "client_peer_table_defines.svh"
module cpt_engine #(
    parameter int TABLE_DEPTH = 16
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           q_valid,
    output logic                           q_ready,
    input  cpt_pkg::cmd_t                  q_cmd,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic                           m_ok,
    output logic [cpt_pkg::ID_W-1:0]       m_node_id,
    output logic [cpt_pkg::ID_W-1:0]       m_conn_id,
    output logic                           m_last,
    output logic [cpt_pkg::CNT_OUT_W-1:0]  m_entry_count
);
    import cpt_pkg::*;

    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CW = $clog2(TABLE_DEPTH + 1);

    typedef enum logic [2:0] {
        S_IDLE, S_P1_RD, S_P1_CHK, S_DECIDE, S_ONE, S_P2_RD, S_P2_CHK
    } state_t;

    state_t             state_reg;
    cmd_t               cmd_reg;
    logic [AW-1:0]      idx_reg, wr_reg;
    logic [CW-1:0]      fill_reg, scan_end_reg, nmatch_reg, target_reg, emitted_reg;
    logic               cdup_reg, removed_reg, res_ok_reg;

    logic               m_valid_reg, m_ok_reg, m_last_reg;
    logic [ID_W-1:0]    m_nid_reg, m_cid_reg;
    logic [CNT_OUT_W-1:0] m_cnt_reg;

    logic                ram_we;
    logic [AW-1:0]       ram_waddr;
    logic [2*ID_W-1:0]   ram_wdata, ram_rdata;
    logic [ID_W-1:0]     rd_node, rd_conn;
    logic can_emit, add_ok, check_ok, scan_last, is_drop, match2, emit2, advance, keep;
    logic emit_one, emit_two;

    cpt_ram #(.WIDTH(2*ID_W), .DEPTH(TABLE_DEPTH)) u_table (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (idx_reg),
        .rdata (ram_rdata)
    );

    assign rd_node   = ram_rdata[2*ID_W-1:ID_W];
    assign rd_conn   = ram_rdata[ID_W-1:0];
    assign can_emit  = !m_valid_reg || m_ready;
    assign add_ok    = cmd_reg.dist_ok && (fill_reg < CW'(TABLE_DEPTH)) &&
                       cmd_reg.bucket_unset && !cdup_reg;
    assign check_ok  = cmd_reg.dist_ok && (fill_reg < CW'(TABLE_DEPTH));
    assign scan_last = (CW'(idx_reg) == (scan_end_reg - CW'(1)));
    assign is_drop   = (cmd_reg.kind == K_DROP_NODE) || (cmd_reg.kind == K_DROP_CONN);
    assign match2    = (cmd_reg.kind == K_DROP_CONN) ?
                       ((rd_conn == cmd_reg.conn_id) && !removed_reg) :
                       (rd_node == cmd_reg.node_id);
    assign emit2     = match2 && ((cmd_reg.kind == K_DROP_CONN) ||
                                  (emitted_reg != target_reg));
    assign advance   = !emit2 || can_emit;
    assign keep      = !(match2 && is_drop);
    assign emit_one  = (state_reg == S_ONE) && can_emit;
    assign emit_two  = (state_reg == S_P2_CHK) && advance && emit2;

    always_comb begin
        if (state_reg == S_DECIDE) begin
            ram_we    = (cmd_reg.kind == K_ADD) && add_ok;
            ram_waddr = fill_reg[AW-1:0];
            ram_wdata = {cmd_reg.node_id, cmd_reg.conn_id};
        end else begin
            ram_we    = (state_reg == S_P2_CHK) && advance && is_drop && keep;
            ram_waddr = wr_reg;
            ram_wdata = ram_rdata;
        end
    end

    assign q_ready         = (state_reg == S_IDLE);
    assign m_valid         = m_valid_reg;
    assign m_ok            = m_ok_reg;
    assign m_node_id       = m_nid_reg;
    assign m_conn_id       = m_cid_reg;
    assign m_last          = m_last_reg;
    assign m_entry_count   = m_cnt_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            fill_reg    <= '0;
            m_valid_reg <= 1'b0;
            emitted_reg <= '0;
            target_reg  <= '0;
        end else begin
            if (emit_one || emit_two) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE: begin
                    if (q_valid) begin
                        cmd_reg      <= q_cmd;
                        idx_reg      <= '0;
                        nmatch_reg   <= '0;
                        cdup_reg     <= 1'b0;
                        scan_end_reg <= fill_reg;
                        state_reg    <= (fill_reg == '0) ? S_DECIDE : S_P1_RD;
                    end
                end
                S_P1_RD: state_reg <= S_P1_CHK;
                S_P1_CHK: begin
                    if (rd_node == cmd_reg.node_id) nmatch_reg <= nmatch_reg + CW'(1);
                    if (rd_conn == cmd_reg.conn_id) cdup_reg <= 1'b1;
                    if (scan_last) begin
                        state_reg <= S_DECIDE;
                    end else begin
                        idx_reg   <= idx_reg + AW'(1);
                        state_reg <= S_P1_RD;
                    end
                end
                S_DECIDE: begin
                    idx_reg      <= '0;
                    wr_reg       <= '0;
                    emitted_reg  <= '0;
                    removed_reg  <= 1'b0;
                    scan_end_reg <= fill_reg;
                    unique case (cmd_reg.kind) inside
                        K_ADD: begin
                            res_ok_reg <= add_ok;
                            if (add_ok) fill_reg <= fill_reg + CW'(1);
                            state_reg  <= S_ONE;
                        end
                        K_CHECK: begin
                            res_ok_reg <= check_ok;
                            state_reg  <= S_ONE;
                        end
                        K_CONTAINS: begin
                            res_ok_reg <= (nmatch_reg != '0);
                            state_reg  <= S_ONE;
                        end
                        K_LIST, K_DROP_NODE: begin
                            res_ok_reg <= 1'b0;
                            if (nmatch_reg != '0) begin
                                if (int'(nmatch_reg) > MAX_RESULTS) begin
                                    target_reg <= CW'(MAX_RESULTS);
                                end else begin
                                    target_reg <= nmatch_reg;
                                end
                                if (cmd_reg.kind == K_DROP_NODE) begin
                                    fill_reg <= fill_reg - nmatch_reg;
                                end
                                state_reg <= S_P2_RD;
                            end else begin
                                state_reg <= S_ONE;
                            end
                        end
                        K_DROP_CONN: begin
                            res_ok_reg <= 1'b0;
                            if (cdup_reg) begin
                                target_reg <= CW'(1);
                                fill_reg   <= fill_reg - CW'(1);
                                state_reg  <= S_P2_RD;
                            end else begin
                                state_reg  <= S_ONE;
                            end
                        end
                        default: begin
                            res_ok_reg <= 1'b0;
                            state_reg  <= S_ONE;
                        end
                    endcase
                end
                S_ONE: begin
                    if (can_emit) begin
                        m_ok_reg    <= res_ok_reg;
                        m_nid_reg   <= '0;
                        m_cid_reg   <= '0;
                        m_last_reg  <= 1'b1;
                        m_cnt_reg   <= CNT_OUT_W'(fill_reg);
                        state_reg   <= S_IDLE;
                    end
                end
                S_P2_RD: state_reg <= S_P2_CHK;
                S_P2_CHK: begin
                    if (advance) begin
                        if (emit2) begin
                            m_ok_reg    <= 1'b1;
                            m_nid_reg   <= rd_node;
                            m_cid_reg   <= rd_conn;
                            m_last_reg  <= (cmd_reg.kind == K_DROP_CONN) ||
                                           ((emitted_reg + CW'(1)) == target_reg);
                            m_cnt_reg   <= CNT_OUT_W'(fill_reg);
                            emitted_reg <= emitted_reg + CW'(1);
                        end
                        if (match2 && (cmd_reg.kind == K_DROP_CONN)) removed_reg <= 1'b1;
                        if (is_drop && keep) wr_reg <= wr_reg + AW'(1);
                        if (scan_last) begin
                            state_reg <= S_IDLE;
                        end else begin
                            idx_reg   <= idx_reg + AW'(1);
                            state_reg <= S_P2_RD;
                        end
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    `CPT_ASSERT_ALWAYS(a_fill_bound, fill_reg <= CW'(TABLE_DEPTH), "fill count past table depth")
    `CPT_ASSERT_ALWAYS(a_emit_bound, emitted_reg <= target_reg, "more matches reported than counted")
    `CPT_ASSERT_NEXT(a_add_grows, (state_reg == S_DECIDE) && (cmd_reg.kind == K_ADD) && add_ok, fill_reg == $past(fill_reg) + CW'(1), "accepted add did not grow table")
endmodule

@@ hdl/client_peer_table.sv @@
// Peer table: holds up to TABLE_DEPTH (node id, connection id) entries in
// insertion order and runs one command per input item: add, check, drop by
// node, drop by connection, list by node, contains. Every command scans the
// table once to count node matches and spot the connection id, reading
// through the registered table RAM; list and both drops then scan again,
// when there is a match, to report matches and close gaps. The engine
// takes a new item only when through with the last; up to two items queue
// ahead of it. Every result carries the entry count after the command; the
// last result of a command has tlast. The user must write own_id through
// cfg_wr_en/cfg_wr_data only while no item is open; not enforced by the block.
module client_peer_table #(
    parameter int TABLE_DEPTH = 16
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_wr_en,
    input  logic [63:0]                       cfg_wr_data,    // own_id
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // node_id[63:0], connection_id[127:64], bucket_unset[128], far_id[192:129]
    input  logic [cpt_pkg::IN_DATA_W-1:0]     s_axis_tdata,
    input  logic [cpt_pkg::OP_W-1:0]          s_axis_tuser,   // op
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // ok[0], out_node_id[64:1], out_connection_id[128:65], entry_count[133:129]
    output logic [cpt_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
    output logic                              m_axis_tlast
);
    import cpt_pkg::*;

    logic [ID_W-1:0]      own_id_reg;
    logic                 q_valid, q_ready;
    cmd_t                 q_cmd;
    logic                 r_ok;
    logic [ID_W-1:0]      r_nid, r_cid;
    logic [CNT_OUT_W-1:0] r_cnt;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            own_id_reg <= '0;
        end else if (cfg_wr_en) begin
            own_id_reg <= cfg_wr_data;
        end
    end

    // front: decode op, precompute the distance test, queue the command
    cpt_front u_front (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .own_id           (own_id_reg),
        .in_valid         (s_axis_tvalid),
        .in_ready         (s_axis_tready),
        .in_op            (s_axis_tuser),
        .in_node_id       (s_axis_tdata[63:0]),
        .in_conn_id       (s_axis_tdata[127:64]),
        .in_bucket_unset  (s_axis_tdata[128]),
        .in_far_id        (s_axis_tdata[192:129]),
        .q_valid          (q_valid),
        .q_ready          (q_ready),
        .q_cmd            (q_cmd)
    );

    // back: table scans, compaction and result output register
    cpt_engine #(.TABLE_DEPTH(TABLE_DEPTH)) u_engine (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .q_valid         (q_valid),
        .q_ready         (q_ready),
        .q_cmd           (q_cmd),
        .m_valid         (m_axis_tvalid),
        .m_ready         (m_axis_tready),
        .m_ok            (r_ok),
        .m_node_id       (r_nid),
        .m_conn_id       (r_cid),
        .m_last          (m_axis_tlast),
        .m_entry_count   (r_cnt)
    );

    assign m_axis_tdata = {2'b00, r_cnt, r_cid, r_nid, r_ok};
endmodule
